// ===== hdl/wvi_pkg.sv =====
// ----------------------------------------------------------------------------
// wvi_pkg
// Shared types and constants of the wavetable voice interpolator.
// ----------------------------------------------------------------------------
package wvi_pkg;

    localparam int SAMPLE_DEPTH_DEF  = 65536;
    localparam int FRACTION_BITS_DEF = 12;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int POS_INT_W  = 17;
    localparam int STEP_W     = 24;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STEP  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_START   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_LENGTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_START   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_LENGTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_LEFT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_RIGHT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO_MODE  = 3'd6;

    typedef struct packed {
        logic [1:0]         operation;
        logic [15:0]        mem_address;
        logic [7:0]         sample_byte;
        logic [23:0]        pitch_step;
        logic signed [31:0] mix_in_left;
        logic signed [31:0] mix_in_right;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] mix_out_left;
        logic signed [31:0] mix_out_right;
        logic               voice_active;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD0,
        S_RD1,
        S_INTERP,
        S_MUL_L,
        S_ACC_L,
        S_ACC_R,
        S_ADV,
        S_WRAP,
        S_EMIT
    } t_state;

endpackage

// ===== hdl/wavetable_voice_interpolator_top.sv =====
// ----------------------------------------------------------------------------
// wavetable_voice_interpolator_top
// One looping wavetable voice with linear interpolation into a mix.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) carries one item: write a sample
// byte, start the voice, or produce one output sample mixed into the incoming
// left accumulator (and in stereo the right one too). Every item gives exactly
// one result item on the output channel (o_out_valid / i_out_stall).
// Configuration registers are written through i_cfg_valid / o_cfg_ready with
// a register index and 16-bit data; write them only while the block is idle.
// Write, start and idle-voice items go from accept straight to the emit state,
// which loads the result. A sample item reads the single sample memory port
// twice, then uses a single shared multiplier for the interpolation and per
// volume (the mean of both in mono), then the advance and wrap update states.
// The input is stalled for the whole of an item's work. One result register
// sits at the output, so a new item is taken while a result still waits;
// the block holds in its last cycle while that register stays stalled.
// Synchronous reset clears configuration, the voice state and the output
// valid; sample memory contents stay undefined until written.
// ----------------------------------------------------------------------------
module wavetable_voice_interpolator_top #(
    parameter int SAMPLE_DEPTH  = wvi_pkg::SAMPLE_DEPTH_DEF,
    parameter int FRACTION_BITS = wvi_pkg::FRACTION_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  wvi_pkg::t_in_item                i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output wvi_pkg::t_out_item               o_out_item,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [wvi_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [wvi_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int AW   = $clog2(SAMPLE_DEPTH);
    localparam int XW   = (AW > 18) ? AW : 18;
    localparam int FB   = FRACTION_BITS;
    localparam int PIW  = wvi_pkg::POS_INT_W;
    localparam int MA_W = FB + 1;
    localparam int MB_W = 9;
    localparam int PRW  = MA_W + MB_W;
    localparam int PW   = 26 + FB;

    wvi_pkg::t_state r_state, n_state;

    logic [15:0] r_wave_start, r_wave_length, r_loop_start, r_loop_length;
    logic [7:0]  r_volume_left, r_volume_right;
    logic        r_stereo_mode;

    logic signed [PIW-1:0]          r_ra;
    logic [FB-1:0]                  r_frac;
    logic [PIW-1:0]                 r_end;
    logic [wvi_pkg::STEP_W-1:0]     r_step;
    logic                           r_playing;

    logic [7:0]                     r_mem [SAMPLE_DEPTH];
    logic [7:0]                     r_rdata;
    logic [7:0]                     r_s0;
    logic [7:0]                     r_d;
    logic signed [PRW-1:0]          r_prod;
    logic signed [31:0]             r_mix_l, r_mix_r;
    logic signed [PW-1:0]           r_pos;
    logic                           r_out_valid;
    wvi_pkg::t_out_item             r_out_item;

    logic                           in_accept;
    logic                           out_free;
    logic [XW-1:0]                  waddr_ext;
    logic [XW-1:0]                  raddr_ext;
    logic [AW-1:0]                  addr0, addr1, rd_addr;
    logic signed [MA_W-1:0]         mul_a;
    logic signed [MB_W-1:0]         mul_b;
    logic signed [PRW-1:0]          mul_p;
    logic signed [MB_W-1:0]         diff;
    logic signed [9:0]              interp_sum;
    logic [7:0]                     interp_d;
    logic signed [8:0]              d_pos, dm128, dm128_r;
    logic [8:0]                     vol_sum;
    logic [7:0]                     vol_half;
    logic signed [31:0]             acc_l;
    logic signed [PW-FB-1:0]        ra_ext;
    logic signed [PW-1:0]           pos_cur;
    logic signed [PW-1:0]           pos_loop;
    logic signed [PW-1:0]           wrap_pos;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != wvi_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_cfg_ready = 1'b1;

    assign waddr_ext = XW'(i_in_item.mem_address);
    assign raddr_ext = XW'(r_end) + XW'(r_ra);
    assign addr0     = raddr_ext[AW-1:0];
    assign addr1     = addr0 + AW'(1);

    assign diff       = $signed({1'b0, r_rdata}) - $signed({1'b0, r_s0});
    assign interp_sum = $signed({2'b00, r_s0}) + r_prod[PRW-1:FB];
    assign interp_d   = interp_sum[7:0];
    assign d_pos      = $signed({1'b0, interp_d});
    assign dm128      = d_pos - 9'sd128;
    assign dm128_r    = $signed({1'b0, r_d}) - 9'sd128;
    assign vol_sum    = {1'b0, r_volume_left} + {1'b0, r_volume_right};
    assign vol_half   = vol_sum[8:1];
    assign mul_p      = mul_a * mul_b;

    assign acc_l = r_stereo_mode ? (r_mix_l + 32'(r_prod))
                                 : (r_mix_l + 32'(r_prod) - 32'({vol_sum, 6'b0}));

    assign ra_ext   = (PW-FB)'(r_ra);
    assign pos_cur  = {ra_ext, r_frac};
    assign pos_loop = r_pos - $signed(PW'({r_loop_length, {FB{1'b0}}}));
    assign wrap_pos = (!r_pos[PW-1] && (r_loop_length != 16'd0)) ? pos_loop : r_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wvi_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        rd_addr = addr0;
        mul_a   = '0;
        mul_b   = '0;
        case (r_state)
            wvi_pkg::S_IDLE: begin
                if (in_accept) begin
                    if (i_in_item.operation == wvi_pkg::OP_STEP && r_playing) begin
                        n_state = wvi_pkg::S_RD0;
                    end else begin
                        n_state = wvi_pkg::S_EMIT;
                    end
                end
            end
            wvi_pkg::S_RD0: begin
                rd_addr = addr0;
                n_state = wvi_pkg::S_RD1;
            end
            wvi_pkg::S_RD1: begin
                rd_addr = addr1;
                n_state = wvi_pkg::S_INTERP;
            end
            wvi_pkg::S_INTERP: begin
                mul_a   = $signed({1'b0, r_frac});
                mul_b   = diff;
                n_state = wvi_pkg::S_MUL_L;
            end
            wvi_pkg::S_MUL_L: begin
                if (r_stereo_mode) begin
                    mul_a = MA_W'(dm128);
                    mul_b = $signed({1'b0, r_volume_left});
                end else begin
                    mul_a = MA_W'(d_pos);
                    mul_b = $signed({1'b0, vol_half});
                end
                n_state = wvi_pkg::S_ACC_L;
            end
            wvi_pkg::S_ACC_L: begin
                mul_a = MA_W'(dm128_r);
                mul_b = $signed({1'b0, r_volume_right});
                n_state = r_stereo_mode ? wvi_pkg::S_ACC_R : wvi_pkg::S_ADV;
            end
            wvi_pkg::S_ACC_R: begin
                n_state = wvi_pkg::S_ADV;
            end
            wvi_pkg::S_ADV: begin
                n_state = wvi_pkg::S_WRAP;
            end
            wvi_pkg::S_WRAP: begin
                n_state = wvi_pkg::S_EMIT;
            end
            wvi_pkg::S_EMIT: begin
                if (out_free) begin
                    n_state = wvi_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = wvi_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_start   <= '0;
            r_wave_length  <= '0;
            r_loop_start   <= '0;
            r_loop_length  <= '0;
            r_volume_left  <= '0;
            r_volume_right <= '0;
            r_stereo_mode  <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                wvi_pkg::CFG_WAVE_START:   r_wave_start   <= i_cfg_data;
                wvi_pkg::CFG_WAVE_LENGTH:  r_wave_length  <= i_cfg_data;
                wvi_pkg::CFG_LOOP_START:   r_loop_start   <= i_cfg_data;
                wvi_pkg::CFG_LOOP_LENGTH:  r_loop_length  <= i_cfg_data;
                wvi_pkg::CFG_VOLUME_LEFT:  r_volume_left  <= i_cfg_data[7:0];
                wvi_pkg::CFG_VOLUME_RIGHT: r_volume_right <= i_cfg_data[7:0];
                wvi_pkg::CFG_STEREO_MODE:  r_stereo_mode  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ra      <= '0;
            r_frac    <= '0;
            r_end     <= '0;
            r_step    <= '0;
            r_playing <= 1'b0;
        end else if (r_state == wvi_pkg::S_IDLE) begin
            if (in_accept && i_in_item.operation == wvi_pkg::OP_START
                    && (r_volume_left | r_volume_right) != 8'd0) begin
                r_step    <= i_in_item.pitch_step;
                r_end     <= {1'b0, r_wave_start} + {1'b0, r_wave_length};
                r_ra      <= PIW'(0) - {1'b0, r_wave_length};
                r_frac    <= '0;
                r_playing <= (r_wave_length != 16'd0);
            end
        end else if (r_state == wvi_pkg::S_WRAP) begin
            if (!r_pos[PW-1]) begin
                if (r_loop_length == 16'd0) begin
                    r_playing <= 1'b0;
                end else begin
                    r_end     <= {1'b0, r_wave_start} + {1'b0, r_loop_start}
                                 + {1'b0, r_loop_length};
                    r_playing <= pos_loop[PW-1];
                end
            end
            r_ra   <= wrap_pos[FB+PIW-1:FB];
            r_frac <= wrap_pos[FB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && i_in_item.operation == wvi_pkg::OP_WRITE) begin
            r_mem[waddr_ext[AW-1:0]] <= i_in_item.sample_byte;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            wvi_pkg::S_IDLE: begin
                r_mix_l <= i_in_item.mix_in_left;
                r_mix_r <= i_in_item.mix_in_right;
            end
            wvi_pkg::S_RD1: begin
                r_s0 <= r_rdata;
            end
            wvi_pkg::S_INTERP: begin
                r_prod <= mul_p;
            end
            wvi_pkg::S_MUL_L: begin
                r_prod <= mul_p;
                r_d    <= interp_d;
            end
            wvi_pkg::S_ACC_L: begin
                r_mix_l <= acc_l;
                r_prod  <= mul_p;
            end
            wvi_pkg::S_ACC_R: begin
                r_mix_r <= r_mix_r + 32'(r_prod);
            end
            wvi_pkg::S_ADV: begin
                r_pos <= pos_cur + $signed(PW'(r_step));
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == wvi_pkg::S_EMIT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == wvi_pkg::S_EMIT && out_free) begin
            r_out_item.mix_out_left  <= r_mix_l;
            r_out_item.mix_out_right <= r_mix_r;
            r_out_item.voice_active  <= r_playing;
        end
    end

endmodule

// ===== hdl/wvi_checker.sv =====
// ----------------------------------------------------------------------------
// wvi_checker
// Port-level checks of the wavetable voice interpolator, bound to the top.
// ----------------------------------------------------------------------------
module wvi_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input wvi_pkg::t_out_item o_out_item
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after an item was accepted");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without an item in work");

    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_out_item_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_item))
        else $error("output item changed while stalled");

endmodule

bind wavetable_voice_interpolator_top wvi_checker u_wvi_checker (.*);
